>>> design/wve_pkg.sv
`timescale 1ns / 1ps
// Shared constants and word types for the windowed velocity estimator.
package wve_pkg;

   localparam int RING_DEPTH  = 16;
   localparam int IDX_W       = $clog2(RING_DEPTH);
   localparam int CNT_W       = $clog2(RING_DEPTH + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int AGE_W       = 16;
   localparam int MOVE_W      = 16;
   localparam int TIME_W      = 32;
   localparam int VEL_W       = 32;
   localparam int HELD_W      = 5;
   localparam int FRAC_W      = 16;
   localparam int DIVIDEND_W  = VEL_W + FRAC_W;
   localparam int STEP_W      = $clog2(DIVIDEND_W + 1);
   localparam int ENTRY_W     = MOVE_W + TIME_W;

   localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = AGE_W'(200);
   localparam logic             MODE_CLEAR      = 1'b1;
   localparam logic [VEL_W-1:0] VEL_MAX         = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic [VEL_W-1:0] VEL_MIN         = {1'b1, {(VEL_W-1){1'b0}}};

   typedef struct packed {
      logic                     mode;
      logic signed [MOVE_W-1:0] movement;
      logic [TIME_W-1:0]        time_ms;
   } req_word_type;

   typedef struct packed {
      logic signed [VEL_W-1:0] velocity_q16;
      logic                    velocity_valid;
      logic [HELD_W-1:0]       samples_held;
   } rsp_word_type;

   typedef struct packed {
      logic                     is_clear;
      logic signed [MOVE_W-1:0] movement;
      logic [TIME_W-1:0]        time_ms;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic             idle;
      logic [CNT_W-1:0] held_count;
   } back_status_type;

endpackage

>>> design/windowed_velocity_estimator_core.sv
`timescale 1ns / 1ps
// Top level of the windowed velocity estimator: configuration register, front end and back end.
// Each request word either adds a timestamped movement sample to a ring of the newest 16 or
// clears the ring, and produces exactly one response word with the windowed velocity in signed
// Q16.16 units per ms. A two-word queue sits between the accepting front end and the back end,
// and the response is held in an output register, so new words are taken while a result waits.
// A clear word, or an add word that leaves fewer than two samples, goes straight to the result.
// An add word with a zero time sum walks the held samples over the single read port of the
// sample RAM, and any other add word also passes through the one-bit-per-cycle divider. The
// age limit resets to 200 ms and should be written only while the block is idle.
module windowed_velocity_estimator_core import wve_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_word_type     req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_word_type     rsp_word,
   input  logic             csr_wr_en,
   input  logic [AGE_W-1:0] csr_wr_data
);

   logic [AGE_W-1:0] age_limit_ff, age_limit_in;
   queue_head_type   head;
   logic             pop;
   back_status_type  status;

   assign age_limit_in = csr_wr_en ? csr_wr_data : age_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_limit_ff <= AGE_LIMIT_RESET;
      end else begin
         age_limit_ff <= age_limit_in;
      end
   end

   wve_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .pop       (pop),
      .head      (head)
   );

   wve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .age_limit (age_limit_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .status    (status)
   );

   // The ring never claims more samples than it can hold.
   assert property (@(posedge clock) disable iff (reset)
      status.held_count <= CNT_W'(RING_DEPTH))
      else $error("Held sample count exceeds the ring depth.");

   // An invalid velocity is always reported as zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.velocity_valid |-> rsp_word.velocity_q16 == '0)
      else $error("Invalid velocity word carries a nonzero value.");

   // The back end only takes a word from the queue when it is idle and a word is there.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> status.idle && head.valid)
      else $error("Queue popped outside the idle state or while empty.");

endmodule

>>> design/wve_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module wve_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/wve_front.sv
`timescale 1ns / 1ps
// Front end: accepts request words, classifies them and queues them for the back end.
module wve_front import wve_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_word_type   req_word,
   input  logic           pop,
   output queue_head_type head
);

   item_type           entry_ff [QUEUE_DEPTH];
   item_type           entry_in;
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               take;

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign take      = pop && (count_ff != '0);

   always_comb begin
      entry_in.is_clear = (req_word.mode == MODE_CLEAR);
      entry_in.movement = req_word.movement;
      entry_in.time_ms  = req_word.time_ms;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

endmodule

>>> design/wve_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle.
module wve_div import wve_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [TIME_W-1:0]     divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [TIME_W-1:0]     rem_ff, rem_in;
   logic [TIME_W-1:0]     div_ff, div_in;
   logic [TIME_W:0]       trial;
   logic [TIME_W:0]       diff;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[TIME_W]) begin
            rem_in = diff[TIME_W-1:0];
         end else begin
            rem_in = trial[TIME_W-1:0];
         end
         quo_in  = {quo_ff[DIVIDEND_W-2:0], !diff[TIME_W]};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> design/wve_back.sv
`timescale 1ns / 1ps
// Back end: updates the sample ring, walks it for the sums, divides and holds the result word.
module wve_back import wve_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic [AGE_W-1:0] age_limit,
   input  queue_head_type  head,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_word_type    rsp_word,
   output back_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_RESULT = 4'b1000
   } back_state_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   back_state_type          state_ff, state_in;
   logic [IDX_W-1:0]        oldest_ff, oldest_in;
   logic [IDX_W-1:0]        write_ff, write_in;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]        issued_ff, issued_in;
   logic                    pend_ff, pend_in;
   logic                    first_ff, first_in;
   logic [TIME_W-1:0]       newest_t_ff, newest_t_in;
   logic [TIME_W-1:0]       prev_t_ff, prev_t_in;
   logic signed [VEL_W-1:0] dist_ff, dist_in;
   logic [TIME_W-1:0]       tsum_ff, tsum_in;
   rsp_word_type            res_ff, res_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_word_type            rsp_word_ff, rsp_word_in;

   logic                    ram_wr_en;
   logic [ENTRY_W-1:0]      ram_wr_data;
   logic [ENTRY_W-1:0]      ram_rd_data;
   logic signed [MOVE_W-1:0] rd_move;
   logic [TIME_W-1:0]       rd_time;
   logic [TIME_W-1:0]       age;
   logic                    in_window;
   logic [TIME_W-1:0]       gap;
   logic signed [VEL_W:0]   dist_wide;
   logic [VEL_W-1:0]        dist_sat;
   logic [TIME_W:0]         tsum_wide;
   logic [TIME_W-1:0]       tsum_sat;
   logic [VEL_W-1:0]        mag;
   logic                    div_start;
   logic                    div_done;
   logic [DIVIDEND_W-1:0]   div_quotient;
   logic                    q_over;
   logic [VEL_W-1:0]        vel_sat;
   logic                    ring_full;
   logic                    out_free;

   wve_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_ff),
      .wr_data (ram_wr_data),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   wve_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mag, FRAC_W'(0)}),
      .divisor  (tsum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign ram_wr_data = {head.item.movement, head.item.time_ms};
   assign rd_move     = ram_rd_data[ENTRY_W-1:TIME_W];
   assign rd_time     = ram_rd_data[TIME_W-1:0];

   assign age       = newest_t_ff - rd_time;
   assign in_window = (age <= {{(TIME_W-AGE_W){1'b0}}, age_limit});
   assign gap       = rd_time - prev_t_ff;

   assign dist_wide = (VEL_W+1)'(dist_ff) + (VEL_W+1)'(rd_move);
   assign dist_sat  = (dist_wide[VEL_W] != dist_wide[VEL_W-1]) ?
                      (dist_wide[VEL_W] ? VEL_MIN : VEL_MAX) : dist_wide[VEL_W-1:0];
   assign tsum_wide = {1'b0, tsum_ff} + {1'b0, gap};
   assign tsum_sat  = tsum_wide[TIME_W] ? '1 : tsum_wide[TIME_W-1:0];

   // Magnitude of the distance sum; the most negative value maps to 2^31 unsigned.
   assign mag     = dist_ff[VEL_W-1] ? (~dist_ff + 1'b1) : dist_ff;
   assign q_over  = (div_quotient[DIVIDEND_W-1:VEL_W-1] != '0);
   assign vel_sat = dist_ff[VEL_W-1] ?
                    (q_over ? VEL_MIN : (~div_quotient[VEL_W-1:0] + 1'b1)) :
                    (q_over ? VEL_MAX : div_quotient[VEL_W-1:0]);

   assign ring_full = (held_ff == CNT_W'(RING_DEPTH));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      write_in     = write_ff;
      held_in      = held_ff;
      rd_idx_in    = rd_idx_ff;
      issued_in    = issued_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      newest_t_in  = newest_t_ff;
      prev_t_in    = prev_t_ff;
      dist_in      = dist_ff;
      tsum_in      = tsum_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      div_start    = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop                 = 1'b1;
               res_in.velocity_q16 = '0;
               res_in.velocity_valid = 1'b0;
               if (head.item.is_clear) begin
                  oldest_in           = '0;
                  write_in            = '0;
                  held_in             = '0;
                  res_in.samples_held = '0;
                  state_in            = ST_RESULT;
               end else begin
                  ram_wr_en   = 1'b1;
                  write_in    = ring_next(write_ff);
                  newest_t_in = head.item.time_ms;
                  if (ring_full) begin
                     oldest_in = ring_next(oldest_ff);
                     rd_idx_in = ring_next(oldest_ff);
                     held_in   = held_ff;
                  end else begin
                     rd_idx_in = oldest_ff;
                     held_in   = held_ff + 1'b1;
                  end
                  res_in.samples_held = HELD_W'(held_in);
                  issued_in = '0;
                  pend_in   = 1'b0;
                  first_in  = 1'b1;
                  dist_in   = '0;
                  tsum_in   = '0;
                  // A single held sample gives no velocity.
                  if (held_ff == '0) begin
                     state_in = ST_RESULT;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            pend_in = (issued_ff != held_ff);
            if (issued_ff != held_ff) begin
               issued_in = issued_ff + 1'b1;
               rd_idx_in = ring_next(rd_idx_ff);
            end
            if (pend_ff) begin
               prev_t_in = rd_time;
               first_in  = 1'b0;
               if (!first_ff && in_window) begin
                  dist_in = dist_sat;
                  tsum_in = tsum_sat;
               end
            end else if (issued_ff == held_ff) begin
               if (tsum_ff == '0) begin
                  state_in = ST_RESULT;
               end else begin
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in.velocity_q16   = vel_sat;
               res_in.velocity_valid = 1'b1;
               state_in              = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         write_ff     <= '0;
         held_ff      <= '0;
         issued_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         write_ff     <= write_in;
         held_ff      <= held_in;
         issued_ff    <= issued_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      first_ff    <= first_in;
      newest_t_ff <= newest_t_in;
      prev_t_ff   <= prev_t_in;
      dist_ff     <= dist_in;
      tsum_ff     <= tsum_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word          = rsp_word_ff;
   assign status.idle       = (state_ff == ST_IDLE);
   assign status.held_count = held_ff;

endmodule

>>> tb/sv/wve_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares the response words of the windowed velocity estimator.
module wve_checker import wve_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  req_word_type     req_word,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  rsp_word_type     rsp_word,
   input  logic             csr_wr_en,
   input  logic [AGE_W-1:0] csr_wr_data,
   output int               mismatch_count,
   output int               pending_words,
   output int               checked_words
);

   localparam longint          DIST_MAX     = 64'sd2147483647;
   localparam longint          DIST_MIN     = -64'sd2147483648;
   localparam longint unsigned TIME_SUM_MAX = 64'hFFFF_FFFF;

   logic signed [MOVE_W-1:0] move_ring [RING_DEPTH];
   logic [TIME_W-1:0]        time_ring [RING_DEPTH];
   int                       oldest_pos;
   int                       write_pos;
   int                       held_samples;
   logic [AGE_W-1:0]         age_limit;
   rsp_word_type             velocity_queue [$];

   always @(posedge clock) begin : watch
      rsp_word_type      want;
      logic [TIME_W-1:0] newest_time;
      logic [TIME_W-1:0] prev_time;
      logic [TIME_W-1:0] sample_age;
      logic [TIME_W-1:0] gap;
      longint            dist_sum;
      longint unsigned   time_sum;
      longint unsigned   magnitude;
      longint unsigned   quotient;
      int                pos;
      if (reset) begin
         oldest_pos = 0;
         write_pos = 0;
         held_samples = 0;
         age_limit = AGE_LIMIT_RESET;
         velocity_queue.delete();
         mismatch_count = 0;
         checked_words = 0;
         pending_words = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            checked_words++;
            if (velocity_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: response word %h arrived with none expected", $time, rsp_word);
               end
            end else begin
               want = velocity_queue.pop_front();
               if (rsp_word.velocity_q16 !== want.velocity_q16 ||
                   rsp_word.velocity_valid !== want.velocity_valid ||
                   rsp_word.samples_held !== want.samples_held) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: velocity %0d/%0d valid %b/%b held %0d/%0d (expected/actual)",
                              $time, want.velocity_q16, rsp_word.velocity_q16,
                              want.velocity_valid, rsp_word.velocity_valid,
                              want.samples_held, rsp_word.samples_held);
                  end
               end
            end
         end

         if (csr_wr_en) begin
            age_limit = csr_wr_data;
         end

         if (req_valid && !req_stall) begin
            if (req_word.mode == MODE_CLEAR) begin
               oldest_pos = 0;
               write_pos = 0;
               held_samples = 0;
            end else begin
               if (held_samples >= RING_DEPTH) begin
                  oldest_pos = (oldest_pos + 1) % RING_DEPTH;
               end else begin
                  held_samples++;
               end
               move_ring[write_pos] = req_word.movement;
               time_ring[write_pos] = req_word.time_ms;
               write_pos = (write_pos + 1) % RING_DEPTH;
            end

            want = '0;
            want.samples_held = HELD_W'(held_samples);
            if (held_samples >= 2) begin
               // The oldest sample only sets the start time of the first gap.
               newest_time = time_ring[(write_pos + RING_DEPTH - 1) % RING_DEPTH];
               prev_time = time_ring[oldest_pos];
               pos = (oldest_pos + 1) % RING_DEPTH;
               dist_sum = 0;
               time_sum = 0;
               repeat (held_samples - 1) begin
                  sample_age = newest_time - time_ring[pos];
                  if (sample_age <= TIME_W'(age_limit)) begin
                     dist_sum += move_ring[pos];
                     if (dist_sum > DIST_MAX) begin
                        dist_sum = DIST_MAX;
                     end else if (dist_sum < DIST_MIN) begin
                        dist_sum = DIST_MIN;
                     end
                     gap = time_ring[pos] - prev_time;
                     time_sum += gap;
                     if (time_sum > TIME_SUM_MAX) begin
                        time_sum = TIME_SUM_MAX;
                     end
                  end
                  prev_time = time_ring[pos];
                  pos = (pos + 1) % RING_DEPTH;
               end
               if (time_sum != 0) begin
                  want.velocity_valid = 1'b1;
                  if (dist_sum < 0) begin
                     magnitude = -dist_sum;
                  end else begin
                     magnitude = dist_sum;
                  end
                  quotient = (magnitude << FRAC_W) / time_sum;
                  if (dist_sum < 0) begin
                     want.velocity_q16 = (quotient >= 64'h8000_0000) ? VEL_MIN : VEL_W'(-quotient);
                  end else begin
                     want.velocity_q16 = (quotient > 64'h7FFF_FFFF) ? VEL_MAX : VEL_W'(quotient);
                  end
               end
            end
            velocity_queue.push_back(want);
         end
         pending_words = velocity_queue.size();
      end
   end

endmodule

>>> tb/sv/tb_windowed_velocity_estimator_core.sv
`timescale 1ns / 1ps
// Testbench top for the windowed velocity estimator core: stimulus, handshakes and verdict.
module tb_windowed_velocity_estimator_core;
   import wve_pkg::*;

   localparam logic              MODE_ADD                 = ~MODE_CLEAR;
   localparam logic [TIME_W-1:0] HALF_RANGE               = 32'h8000_0000;
   localparam int                RANDOM_WORDS_PER_SETTING = 64;
   localparam int                DRAIN_CYCLES             = 80;

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_type;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_stall;
   req_word_type     req_word    = '0;
   logic             rsp_valid;
   logic             rsp_stall   = 1'b0;
   rsp_word_type     rsp_word;
   logic             csr_wr_en   = 1'b0;
   logic [AGE_W-1:0] csr_wr_data = '0;

   int              mismatch_count;
   int              pending_words;
   int              checked_words;
   int              words_sent    = 0;
   int              clears_sent   = 0;
   int              settings_used = 0;
   stall_style_type stall_style   = STALL_NONE;
   int              stall_left    = 0;

   always #1 clock = ~clock;

   windowed_velocity_estimator_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   wve_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word       (rsp_word),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_words  (pending_words),
      .checked_words  (checked_words)
   );

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style <= stall_style_type'($urandom_range(0, 3));
         stall_left  <= $urandom_range(16, 300);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= ((stall_left % 24) < 12);
         end
      endcase
   end

   function automatic req_word_type sample_word(input logic              mode,
                                                input logic [MOVE_W-1:0] movement,
                                                input logic [TIME_W-1:0] time_ms);
      req_word_type w;
      w.mode     = mode;
      w.movement = movement;
      w.time_ms  = time_ms;
      return w;
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      words_sent++;
      if (w.mode == MODE_CLEAR) begin
         clears_sent++;
      end
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] now_ms;
      logic [TIME_W-1:0] gap_ms;
      logic [AGE_W-1:0]  age_setting;
      logic [AGE_W-1:0]  settings [7];
      logic [MOVE_W-1:0] movement;
      int                burst_left;
      int                pick;

      settings = '{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd200, 16'd20, 16'd0};
      settings[3] = AGE_W'($urandom);
      settings[6] = AGE_W'($urandom_range(2, 1000));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty ring, too few samples, zero time sum, then exact and saturated velocities.
      send_word(sample_word(MODE_CLEAR, MOVE_W'($urandom), $urandom));
      send_word(sample_word(MODE_ADD, 16'h7FFF, 32'd0));
      send_word(sample_word(MODE_ADD, 16'h8000, 32'd0));
      send_word(sample_word(MODE_ADD, 16'h7FFF, 32'd1));
      send_word(sample_word(MODE_CLEAR, MOVE_W'($urandom), $urandom));
      send_word(sample_word(MODE_ADD, 16'd0, 32'd100));
      send_word(sample_word(MODE_ADD, 16'h7FFF, 32'd100));
      send_word(sample_word(MODE_ADD, 16'h7FFF, 32'd101));
      send_word(sample_word(MODE_CLEAR, MOVE_W'($urandom), $urandom));
      send_word(sample_word(MODE_ADD, 16'd0, 32'd0));
      send_word(sample_word(MODE_ADD, 16'h8000, 32'd1));
      send_word(sample_word(MODE_ADD, 16'h8000, 32'd2));

      // A sample exactly at the age limit counts, an older one does not.
      send_word(sample_word(MODE_CLEAR, MOVE_W'($urandom), $urandom));
      send_word(sample_word(MODE_ADD, 16'd5, 32'd0));
      send_word(sample_word(MODE_ADD, 16'd5, 32'd1000));
      send_word(sample_word(MODE_ADD, 16'd7, 32'd1100));
      send_word(sample_word(MODE_ADD, MOVE_W'(-3), 32'd1300));

      // Time stamps that wrap, then gaps whose sum overflows the time sum.
      send_word(sample_word(MODE_CLEAR, MOVE_W'($urandom), $urandom));
      send_word(sample_word(MODE_ADD, 16'd1, 32'hFFFF_FFF0));
      send_word(sample_word(MODE_ADD, 16'd2, 32'h0000_0010));
      send_word(sample_word(MODE_CLEAR, MOVE_W'($urandom), $urandom));
      send_word(sample_word(MODE_ADD, 16'd1000, 32'd0));
      send_word(sample_word(MODE_ADD, 16'd1000, HALF_RANGE - 5));
      send_word(sample_word(MODE_ADD, 16'd1000, HALF_RANGE + 100000));
      send_word(sample_word(MODE_ADD, 16'd1000, HALF_RANGE - 3));
      send_word(sample_word(MODE_ADD, MOVE_W'(-7), HALF_RANGE));

      burst_left = $urandom_range(1, 20);
      foreach (settings[s]) begin
         req_valid <= 1'b0;
         while (pending_words != 0) @(negedge clock);
         csr_wr_en   <= 1'b1;
         csr_wr_data <= settings[s];
         @(negedge clock);
         csr_wr_en <= 1'b0;
         age_setting = settings[s];
         settings_used++;
         now_ms = $urandom;

         repeat (RANDOM_WORDS_PER_SETTING) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               movement = MOVE_W'($urandom);
            end else if (pick < 85) begin
               movement = MOVE_W'($urandom_range(0, 40) - 20);
            end else begin
               movement = pick[0] ? 16'h7FFF : 16'h8000;
            end

            pick = $urandom_range(0, 99);
            if (pick < 10) begin
               gap_ms = '0;
            end else if (pick < 65) begin
               gap_ms = $urandom_range(1, age_setting / 8 + 2);
            end else if (pick < 85) begin
               gap_ms = $urandom_range(1, age_setting + 50);
            end else begin
               gap_ms = $urandom;
            end

            // Mostly a steady stream of samples; a few clears and out-of-order stamps.
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send_word(sample_word(MODE_CLEAR, movement, $urandom));
            end else if (pick < 10) begin
               send_word(sample_word(MODE_ADD, movement, $urandom));
            end else begin
               now_ms += gap_ms;
               send_word(sample_word(MODE_ADD, movement, now_ms));
            end

            burst_left--;
            if (burst_left == 0) begin
               req_valid <= 1'b0;
               if ($urandom_range(0, 3) == 0) begin
                  repeat ($urandom_range(20, 90)) @(negedge clock);
               end else begin
                  repeat ($urandom_range(1, 8)) @(negedge clock);
               end
               burst_left = $urandom_range(1, 20);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Drove %0d request words, %0d of them clears, %s %0d more.",
               words_sent, clears_sent, "under the reset age limit and", settings_used);
      $display("Compared %0d response words with the predicted velocities.", checked_words);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("Mismatches found");
      $finish;
   end

endmodule

>>> files.f
design/wve_pkg.sv
design/wve_ram.sv
design/wve_front.sv
design/wve_div.sv
design/wve_back.sv
design/windowed_velocity_estimator_core.sv
tb/sv/wve_checker.sv
tb/sv/tb_windowed_velocity_estimator_core.sv
